[rtl/cstu_pkg.sv]
`timescale 1ns / 1ps

package cstu_pkg;

	// histogram geometry
	localparam int MAX_BINS = 1024;
	localparam int COUNT_W  = 32;
	localparam int BIN_W    = $clog2(MAX_BINS);
	localparam int BINS_W   = $clog2(MAX_BINS + 1);

	// port field widths
	localparam int CFG_W    = 11;
	localparam int SAMPLE_W = 10;
	localparam int CHI_W    = 63;
	localparam int TOTAL_W  = 32;

	localparam logic [CFG_W-1:0] BINS_RESET = CFG_W'(1000);

	// statistic datapath widths
	localparam int SQ_W   = 2 * COUNT_W;
	localparam int P1_W   = BINS_W + SQ_W;
	localparam int NUM_W  = P1_W + 1;
	localparam int FRAC_W = 16;
	localparam int DIVN_W = NUM_W + FRAC_W;
	localparam int DIVC_W = $clog2(DIVN_W);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CHI_W-1:0]   CHI_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef struct packed {
		logic [BIN_W-1:0]   bin;
		logic               count_en;
		logic               fin;
		logic [COUNT_W-1:0] n;
		logic               sat;
		logic               bad;
	} cmd_t;

	typedef struct packed {
		logic [CHI_W-1:0]   chi;
		logic [TOTAL_W-1:0] total;
		logic               sat;
		logic               bad;
	} res_t;

	typedef enum logic [3:0] {
		BK_INIT,
		BK_RUN,
		BK_SWEEP,
		BK_FLUSH,
		BK_MUL_A,
		BK_MUL_B,
		BK_MUL_C,
		BK_SUM,
		BK_DIV_GO,
		BK_DIV_WAIT,
		BK_OUT
	} bk_state_t;

endpackage

[rtl/cstu_front.sv]
`timescale 1ns / 1ps

module cstu_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [cstu_pkg::SAMPLE_W-1:0] sample_bin,
	input  logic                          final_req,
	input  logic                          cfg_we,
	input  logic [cstu_pkg::CFG_W-1:0]    cfg_wdata,
	output cstu_pkg::cmd_t                q_data,
	output logic [cstu_pkg::BINS_W-1:0]   eff_bins
);
	import cstu_pkg::*;

	function automatic logic [BINS_W-1:0] eff_bins_f(input logic [CFG_W-1:0] v);
		logic [BINS_W-1:0] r;
		if (v == '0) begin
			r = BINS_W'(1);
		end else if (int'(v) > MAX_BINS) begin
			r = BINS_W'(MAX_BINS);
		end else begin
			r = BINS_W'(v);
		end
		return r;
	endfunction

	logic [CFG_W-1:0]   bins_q;
	logic [COUNT_W-1:0] count_q;
	logic               csat_q;
	logic               bad_q;

	logic               in_range;
	logic               cnt_full;
	logic               count_en;
	logic [COUNT_W-1:0] cnt_next;

	always_comb begin
		eff_bins = eff_bins_f(bins_q);
		in_range = BINS_W'(sample_bin) < eff_bins;
		cnt_full = count_q == COUNT_MAX;
		count_en = in_range && !cnt_full;
		cnt_next = count_en ? count_q + COUNT_W'(1) : count_q;

		q_data.bin      = BIN_W'(sample_bin);
		q_data.count_en = count_en;
		q_data.fin      = final_req;
		q_data.n        = cnt_next;
		q_data.sat      = csat_q | (in_range & cnt_full);
		q_data.bad      = bad_q | !in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q  <= BINS_RESET;
			count_q <= '0;
			csat_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				bins_q <= cfg_wdata;
			end
			if (accept) begin
				if (final_req) begin
					count_q <= '0;
					csat_q  <= 1'b0;
					bad_q   <= 1'b0;
				end else begin
					count_q <= cnt_next;
					csat_q  <= q_data.sat;
					bad_q   <= q_data.bad;
				end
			end
		end
	end

endmodule

[rtl/cstu_fifo.sv]
`timescale 1ns / 1ps

module cstu_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cstu_pkg::cmd_t wdata,
	input  logic           pop,
	output cstu_pkg::cmd_t rdata,
	output logic           empty,
	output logic           full
);
	import cstu_pkg::*;

	cmd_t            ent_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;

	logic do_push;
	logic do_pop;

	always_comb begin
		empty   = cnt_q == '0;
		full    = cnt_q == (Q_AW+1)'(Q_DEPTH);
		rdata   = ent_q[rd_ptr_q];
		do_push = push && !full;
		do_pop  = pop && !empty;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/cstu_div.sv]
`timescale 1ns / 1ps

module cstu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cstu_pkg::DIVN_W-1:0] num,
	input  logic [cstu_pkg::COUNT_W-1:0] den,
	output logic                        done,
	output logic [cstu_pkg::DIVN_W-1:0] quo
);
	import cstu_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DIVC_W-1:0]  cnt_q;
	logic [DIVN_W-1:0]  sh_q;   // numerator shifts out on top, quotient shifts in below
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] den_q;

	logic [COUNT_W:0] rem_sh;
	logic [COUNT_W:0] rem_nx;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, sh_q[DIVN_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
		done   = done_q;
		quo    = sh_q;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			sh_q  <= {sh_q[DIVN_W-2:0], ge};
			rem_q <= rem_nx[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIVC_W'(1);
				if (cnt_q == DIVC_W'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/cstu_back.sv]
`timescale 1ns / 1ps

module cstu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  cstu_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	input  logic [cstu_pkg::BINS_W-1:0] eff_bins,
	output logic                        init_busy,
	output logic                        res_valid,
	output cstu_pkg::res_t              res,
	input  logic                        res_ready
);
	import cstu_pkg::*;

	localparam int NX_W = (COUNT_W > TOTAL_W) ? COUNT_W : TOTAL_W;

	bk_state_t state_q, state_d;

	// histogram memory
	logic [COUNT_W-1:0] mem [MAX_BINS];
	logic [COUNT_W-1:0] rd_q;

	logic [BIN_W-1:0] sw_q;
	logic             sw_last;

	// issue
	logic             iss_valid;
	logic             iss_sweep;
	logic             iss_sum;
	logic [BIN_W-1:0] iss_addr;

	// read stage
	logic               s1_valid_q;
	logic               s1_sweep_q;
	logic               s1_sum_q;
	logic [BIN_W-1:0]   s1_addr_q;
	logic [COUNT_W-1:0] s1_val;

	// write port and bypass of the write that lands with a read
	logic               wr_en;
	logic [BIN_W-1:0]   wr_addr;
	logic [COUNT_W-1:0] wr_data;
	logic               wr_vld_q;
	logic [BIN_W-1:0]   wr_addr_q;
	logic [COUNT_W-1:0] wr_data_q;

	// square stage and sums
	logic               s2_valid_q;
	logic [SQ_W-1:0]    sq_s2;
	logic [COUNT_W-1:0] v_s2;
	logic [SQ_W-1:0]    sum_sq_q;
	logic [COUNT_W-1:0] sum1_q;

	// per-set status latched at the final request
	logic [COUNT_W-1:0] n_q;
	logic               sat_q;
	logic               bad_q;

	// bins * sum of squares, low half in MUL_A, high half in MUL_B
	logic [BINS_W+COUNT_W-1:0] p1_part;
	logic [P1_W-1:0]  p1_q;
	logic [SQ_W-1:0]  nn_q;
	logic [SQ_W-1:0]  ns1_q;
	logic [NUM_W-1:0] num_q;

	logic              div_start;
	logic              div_done;
	logic [DIVN_W-1:0] div_quo;
	logic              chi_sat;

	logic [CHI_W-1:0] chi_q;
	logic             fsat_q;

	logic [NX_W-1:0] n_x;
	logic            tot_sat;

	cstu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({num_q, FRAC_W'(0)}),
		.den    (n_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		iss_valid = 1'b0;
		iss_sweep = 1'b0;
		iss_addr  = sw_q;
		iss_sum   = BINS_W'(sw_q) < eff_bins;
		div_start = 1'b0;
		res_valid = 1'b0;
		init_busy = 1'b0;
		sw_last   = sw_q == BIN_W'(MAX_BINS - 1);
		case (state_q)
			BK_INIT: begin
				init_busy = 1'b1;
				if (sw_last) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (cmd_valid) begin
					cmd_pop   = 1'b1;
					iss_valid = cmd.count_en;
					iss_addr  = cmd.bin;
					if (cmd.fin) begin
						state_d = BK_SWEEP;
					end
				end
			end
			BK_SWEEP: begin
				iss_valid = 1'b1;
				iss_sweep = 1'b1;
				if (sw_last) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!s1_valid_q && !s2_valid_q) begin
					state_d = (n_q == '0) ? BK_OUT : BK_MUL_A;
				end
			end
			BK_MUL_A: state_d = BK_MUL_B;
			BK_MUL_B: state_d = BK_MUL_C;
			BK_MUL_C: state_d = BK_SUM;
			BK_SUM:   state_d = BK_DIV_GO;
			BK_DIV_GO: begin
				div_start = 1'b1;
				state_d   = BK_DIV_WAIT;
			end
			BK_DIV_WAIT: begin
				if (div_done) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_comb begin
		s1_val  = (wr_vld_q && wr_addr_q == s1_addr_q) ? wr_data_q : rd_q;
		wr_en   = (state_q == BK_INIT) || s1_valid_q;
		wr_addr = (state_q == BK_INIT) ? sw_q : s1_addr_q;
		wr_data = ((state_q == BK_INIT) || s1_sweep_q) ? '0 : s1_val + COUNT_W'(1);
		p1_part = (BINS_W+COUNT_W)'(eff_bins) *
		          (BINS_W+COUNT_W)'((state_q == BK_MUL_B) ? sum_sq_q[SQ_W-1:COUNT_W]
		                                                  : sum_sq_q[COUNT_W-1:0]);
		chi_sat = |div_quo[DIVN_W-1:CHI_W];
		n_x     = NX_W'(n_q);
		tot_sat = n_x > NX_W'(TOTAL_MAX);

		res.chi   = chi_q;
		res.total = tot_sat ? TOTAL_MAX : TOTAL_W'(n_x);
		res.sat   = fsat_q | tot_sat;
		res.bad   = bad_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (iss_valid) begin
			rd_q <= mem[iss_addr];
		end
	end

	always_ff @(posedge clk) begin
		s1_addr_q <= iss_addr;
		s1_sweep_q <= iss_sweep;
		s1_sum_q  <= iss_sum;
		wr_addr_q <= wr_addr;
		wr_data_q <= wr_data;
		sq_s2     <= SQ_W'(s1_val) * SQ_W'(s1_val);
		v_s2      <= s1_val;

		if (cmd_pop && cmd.fin) begin
			n_q      <= cmd.n;
			sat_q    <= cmd.sat;
			bad_q    <= cmd.bad;
			sum_sq_q <= '0;
			sum1_q   <= '0;
		end else if (s2_valid_q) begin
			sum_sq_q <= sum_sq_q + sq_s2;
			sum1_q   <= sum1_q + v_s2;
		end

		case (state_q)
			BK_FLUSH: begin
				chi_q  <= '0;
				fsat_q <= sat_q;
			end
			BK_MUL_A: p1_q  <= P1_W'(p1_part);
			BK_MUL_B: begin
				p1_q <= p1_q + (P1_W'(p1_part) << COUNT_W);
				nn_q <= SQ_W'(n_q) * SQ_W'(n_q);
			end
			BK_MUL_C: ns1_q <= SQ_W'(n_q) * SQ_W'(sum1_q);
			BK_SUM:   num_q <= NUM_W'(p1_q) + NUM_W'(nn_q) - (NUM_W'(ns1_q) << 1);
			BK_DIV_WAIT: begin
				if (div_done) begin
					chi_q  <= chi_sat ? CHI_MAX : div_quo[CHI_W-1:0];
					fsat_q <= sat_q | chi_sat;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_INIT;
			sw_q       <= '0;
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			wr_vld_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			s1_valid_q <= iss_valid;
			s2_valid_q <= s1_valid_q && s1_sweep_q && s1_sum_q;
			wr_vld_q   <= wr_en;
			if (state_q == BK_INIT || state_q == BK_SWEEP) begin
				sw_q <= sw_last ? '0 : sw_q + BIN_W'(1);
			end
		end
	end

endmodule

[rtl/chi_square_uniformity_test_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Payload
// sample    in         push / full      sample_bin, final_req
// result    out        empty / pop      chi_square_q16, sample_total, saturated, range_error
// config    in         cfg_we           cfg_wdata (bins_in_use)
//
// A sample request is taken while full is low and counted into the histogram at one per
// cycle while the back runs. A final request adds a sweep of all MAX_BINS (1024) bins of
// the histogram memory, a drain of the read and square stages, multiply and sum (MUL_A,
// MUL_B, MUL_C, SUM) and the 92-step bit-serial divide; empty falls when the result is
// registered (N = 0 skips multiply and divide). After reset the histogram memory is
// cleared; full stays high meanwhile. The front feeds a four-entry command queue; full
// also rises when it fills, which happens when requests keep coming while the back sweeps,
// computes or holds a result. A result waits in the output register until popped.

module chi_square_uniformity_test_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [cstu_pkg::SAMPLE_W-1:0] sample_bin,
	input  logic                          final_req,
	output logic                          empty,
	input  logic                          pop,
	output logic [cstu_pkg::CHI_W-1:0]    chi_square_q16,
	output logic [cstu_pkg::TOTAL_W-1:0]  sample_total,
	output logic                          saturated,
	output logic                          range_error,
	input  logic                          cfg_we,
	input  logic [cstu_pkg::CFG_W-1:0]    cfg_wdata
);
	import cstu_pkg::*;

	logic              accept;
	cmd_t              q_wdata;
	cmd_t              q_rdata;
	logic              q_empty;
	logic              q_full;
	logic              q_pop;
	logic [BINS_W-1:0] eff_bins;
	logic              init_busy;

	logic res_valid;
	logic res_ready;
	res_t res;

	// output register
	logic out_vld_q;
	res_t out_q;

	always_comb begin
		// no sample is taken while the clearing pass after reset runs
		full      = q_full | init_busy;
		accept    = push & !full;
		empty     = !out_vld_q;
		res_ready = !out_vld_q | pop;

		chi_square_q16 = out_q.chi;
		sample_total   = out_q.total;
		saturated      = out_q.sat;
		range_error    = out_q.bad;
	end

	// front: classifies bins, tracks count and flags of the open set
	cstu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.sample_bin (sample_bin),
		.final_req  (final_req),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_data     (q_wdata),
		.eff_bins   (eff_bins)
	);

	cstu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.full   (q_full)
	);

	// back: histogram memory, final sweep and statistic
	cstu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (q_rdata),
		.cmd_pop   (q_pop),
		.eff_bins  (eff_bins),
		.init_busy (init_busy),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule
